>>> src/aipfb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aipfb_pkg
// Shared types and constants of the auto-increment plane framebuffer.
// ---------------------------------------------------------------------------
package aipfb_pkg;

   localparam int unsigned COORD_W   = 8;
   localparam int unsigned ADDR_W    = 2 * COORD_W;
   localparam int unsigned PIXEL_W   = 8;
   localparam int unsigned COLOR_W   = 16;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 8;

   typedef enum logic [1:0] {
      CMD_WRITE_PIXEL = 2'd0,
      CMD_LOAD_COLUMN = 2'd1,
      CMD_LOAD_ROW    = 2'd2,
      CMD_SCREEN_READ = 2'd3
   } cmd_type;

   localparam logic [CSR_IDX_W-1:0] REG_DRAW_DIRECTION = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VIDEO_ENABLE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCROLL_X       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SCROLL_Y       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PALETTE_BASE   = 3'd4;

   typedef struct packed {
      logic               draw_direction;
      logic               video_enable;
      logic [COORD_W-1:0] scroll_x;
      logic [COORD_W-1:0] scroll_y;
      logic [COORD_W-1:0] palette_base;
   } cfg_type;

endpackage

>>> src/aipfb_plane_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aipfb_plane_ram
// 64K x 8 plane store, one write port and one registered read port.
// ---------------------------------------------------------------------------
module aipfb_plane_ram (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [aipfb_pkg::ADDR_W-1:0]   wr_addr,
   input  logic [aipfb_pkg::PIXEL_W-1:0]  wr_data,
   input  logic                           rd_en,
   input  logic [aipfb_pkg::ADDR_W-1:0]   rd_addr,
   output logic [aipfb_pkg::PIXEL_W-1:0]  rd_data
);

   localparam int unsigned DEPTH = 1 << aipfb_pkg::ADDR_W;

   logic [aipfb_pkg::PIXEL_W-1:0] mem [DEPTH];
   logic [aipfb_pkg::PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/aipfb_csr.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aipfb_csr
// Configuration register file: draw direction, enable, scroll and palette.
// ---------------------------------------------------------------------------
module aipfb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [aipfb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [aipfb_pkg::CSR_DAT_W-1:0]  csr_data,
   output aipfb_pkg::cfg_type               cfg
);

   aipfb_pkg::cfg_type cfg_ff;
   aipfb_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            aipfb_pkg::REG_DRAW_DIRECTION: cfg_in.draw_direction = csr_data[0];
            aipfb_pkg::REG_VIDEO_ENABLE:   cfg_in.video_enable   = csr_data[0];
            aipfb_pkg::REG_SCROLL_X:       cfg_in.scroll_x       = csr_data;
            aipfb_pkg::REG_SCROLL_Y:       cfg_in.scroll_y       = csr_data;
            aipfb_pkg::REG_PALETTE_BASE:   cfg_in.palette_base   = csr_data;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

>>> src/auto_increment_plane_framebuffer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// auto_increment_plane_framebuffer
// 256x256 byte video plane with auto-incrementing draw pointers and a
// scrolled, paletted screen read.
// ---------------------------------------------------------------------------
// After reset the block sweeps the plane store to zero, one byte per cycle,
// over all 65536 addresses; req_stall stays high during the sweep while csr
// writes are taken as usual. Then it accepts one request per cycle unless
// rsp_stall holds a full output. Each request touches the single port pair
// of the plane memory in the cycle it is accepted; its response passes the
// read data and output registers in turn. Every request gives one response.
module auto_increment_plane_framebuffer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_command,
   input  logic [7:0]                       req_write_data,
   input  logic [7:0]                       req_screen_x,
   input  logic [7:0]                       req_screen_y,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_visible,
   output logic [15:0]                      rsp_color_index,
   output logic [7:0]                       rsp_pixel_value,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [aipfb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [aipfb_pkg::CSR_DAT_W-1:0]  csr_data
);

   aipfb_pkg::cfg_type cfg;
   aipfb_pkg::cmd_type cmd;

   logic                           clr_ff;
   logic [aipfb_pkg::ADDR_W-1:0]   clr_cnt_ff;
   logic [aipfb_pkg::COORD_W-1:0]  row_ff, row_in;
   logic [aipfb_pkg::COORD_W-1:0]  col_ff, col_in;
   logic                           s1_valid_ff, s1_valid_in;
   logic                           s1_read_ff, s1_read_in;
   logic                           out_valid_ff, out_valid_in;
   logic                           out_visible_ff, out_visible_in;
   logic [aipfb_pkg::COLOR_W-1:0]  out_color_ff, out_color_in;
   logic [aipfb_pkg::PIXEL_W-1:0]  out_pixel_ff, out_pixel_in;

   logic                           accept;
   logic                           out_free;
   logic                           wr_en;
   logic [aipfb_pkg::ADDR_W-1:0]   wr_addr;
   logic [aipfb_pkg::PIXEL_W-1:0]  wr_data;
   logic                           rd_en;
   logic [aipfb_pkg::ADDR_W-1:0]   rd_addr;
   logic [aipfb_pkg::PIXEL_W-1:0]  rd_data;
   logic [aipfb_pkg::COORD_W-1:0]  rd_row;
   logic [aipfb_pkg::COORD_W-1:0]  rd_col;

   aipfb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   aipfb_plane_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cmd       = aipfb_pkg::cmd_type'(req_command);
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = clr_ff || (s1_valid_ff && !out_free);
   assign accept    = req_valid && !req_stall;

   assign rd_row  = req_screen_y + cfg.scroll_y;
   assign rd_col  = req_screen_x + cfg.scroll_x;
   assign rd_addr = {rd_row, rd_col};
   assign rd_en   = accept && (cmd == aipfb_pkg::CMD_SCREEN_READ);

   // store port: clearing sweep, else pixel write at the draw pointers
   always_comb begin
      if (clr_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end else begin
         wr_en   = accept && (cmd == aipfb_pkg::CMD_WRITE_PIXEL);
         wr_addr = {row_ff, col_ff};
         wr_data = req_write_data;
      end
   end

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         case (cmd)
            aipfb_pkg::CMD_WRITE_PIXEL: begin
               if (cfg.draw_direction) begin
                  col_in = col_ff + 1'b1;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end
            aipfb_pkg::CMD_LOAD_COLUMN: col_in = req_write_data;
            aipfb_pkg::CMD_LOAD_ROW:    row_in = req_write_data;
            default: begin
               row_in = row_ff;
               col_in = col_ff;
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_read_in  = s1_read_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_read_in  = (cmd == aipfb_pkg::CMD_SCREEN_READ);
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_visible_in = out_visible_ff;
      out_color_in   = out_color_ff;
      out_pixel_in   = out_pixel_ff;
      if (out_free) begin
         out_valid_in   = s1_valid_ff;
         out_pixel_in   = s1_read_ff ? rd_data : '0;
         out_visible_in = (out_pixel_in != '0) && cfg.video_enable;
         out_color_in   = out_visible_in ? {cfg.palette_base, out_pixel_in} : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= 1'b1;
         clr_cnt_ff   <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (&clr_cnt_ff) begin
               clr_ff <= 1'b0;
            end
         end
         row_ff       <= row_in;
         col_ff       <= col_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_read_ff     <= s1_read_in;
      out_visible_ff <= out_visible_in;
      out_color_ff   <= out_color_in;
      out_pixel_ff   <= out_pixel_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_visible     = out_visible_ff;
   assign rsp_color_index = out_color_ff;
   assign rsp_pixel_value = out_pixel_ff;

   // no request taken while the store is being swept
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> req_stall)
      else $error("request accepted during clearing sweep");

   // a read waiting behind a blocked output stays put
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && rsp_stall |=> s1_valid_ff)
      else $error("pending read lost while output stalled");

   // column advances on a pixel write in column direction
   a_col_step: assert property (@(posedge clock) disable iff (reset)
      accept && (cmd == aipfb_pkg::CMD_WRITE_PIXEL) && cfg.draw_direction
      |=> col_ff == $past(col_ff) + 8'd1)
      else $error("column pointer did not advance");

   // visible response carries the pixel in the low byte
   a_visible_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_visible |->
      (rsp_pixel_value != 8'd0) && (rsp_color_index[7:0] == rsp_pixel_value))
      else $error("visible response inconsistent with pixel");

   // transparent response carries no colour
   a_transparent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_color_index == 16'd0)
      else $error("transparent response with nonzero color");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the auto-increment plane framebuffer. Requests are
// driven through the valid/stall port under several idle and stall mixes,
// across a range of register settings. A small scoreboard keeps its own
// copy of the plane, the draw pointers and the registers, predicts each
// response and compares it field by field in order.
// ---------------------------------------------------------------------------
module tb_top;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam int PHASES = 12;
   localparam int PHASE_REQUESTS = 130;
   localparam int DRAWN_KEEP = 64;
   localparam int REPORT_CAP = 100;

   typedef struct packed {
      logic                         visible;
      logic [aipfb_pkg::COLOR_W-1:0] color_index;
      logic [aipfb_pkg::PIXEL_W-1:0] pixel_value;
   } pixel_result_type;

   class plane_scoreboard;
      aipfb_pkg::cfg_type            regs;
      logic [aipfb_pkg::PIXEL_W-1:0] plane [0:65535];
      logic [aipfb_pkg::COORD_W-1:0] row_ptr;
      logic [aipfb_pkg::COORD_W-1:0] col_ptr;
      logic [aipfb_pkg::ADDR_W-1:0]  drawn [$];
      pixel_result_type              pending_pixels [$];
      int                            errors;

      function new();
         foreach (plane[i]) plane[i] = '0;
         regs = '0;
         row_ptr = '0;
         col_ptr = '0;
         errors = 0;
      endfunction

      task report(input string msg);
         if (errors < REPORT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      function void write_reg(input logic [aipfb_pkg::CSR_IDX_W-1:0] idx,
                              input logic [aipfb_pkg::CSR_DAT_W-1:0] data);
         case (idx)
            aipfb_pkg::REG_DRAW_DIRECTION: regs.draw_direction = data[0];
            aipfb_pkg::REG_VIDEO_ENABLE:   regs.video_enable = data[0];
            aipfb_pkg::REG_SCROLL_X:       regs.scroll_x = data;
            aipfb_pkg::REG_SCROLL_Y:       regs.scroll_y = data;
            aipfb_pkg::REG_PALETTE_BASE:   regs.palette_base = data;
            default: ;
         endcase
      endfunction

      function void note_request(input aipfb_pkg::cmd_type cmd, input logic [7:0] data,
                                 input logic [7:0] sx, input logic [7:0] sy);
         pixel_result_type              res;
         logic [aipfb_pkg::COORD_W-1:0] row;
         logic [aipfb_pkg::COORD_W-1:0] col;
         res = '0;
         case (cmd)
            aipfb_pkg::CMD_WRITE_PIXEL: begin
               plane[{row_ptr, col_ptr}] = data;
               drawn.push_back({row_ptr, col_ptr});
               if (drawn.size() > DRAWN_KEEP) void'(drawn.pop_front());
               if (regs.draw_direction) col_ptr = col_ptr + 1'b1;
               else row_ptr = row_ptr + 1'b1;
            end
            aipfb_pkg::CMD_LOAD_COLUMN: col_ptr = data;
            aipfb_pkg::CMD_LOAD_ROW:    row_ptr = data;
            aipfb_pkg::CMD_SCREEN_READ: begin
               row = sy + regs.scroll_y;
               col = sx + regs.scroll_x;
               res.pixel_value = plane[{row, col}];
               if (res.pixel_value != '0 && regs.video_enable) begin
                  res.visible = 1'b1;
                  res.color_index = {regs.palette_base, 8'h00} + {8'h00, res.pixel_value};
               end
            end
            default: ;
         endcase
         pending_pixels.push_back(res);
      endfunction

      task check_pixel(input logic vis, input logic [aipfb_pkg::COLOR_W-1:0] color,
                       input logic [aipfb_pkg::PIXEL_W-1:0] pix);
         pixel_result_type want;
         if (pending_pixels.size() == 0) begin
            report("response with no request outstanding");
         end else begin
            want = pending_pixels.pop_front();
            if (vis !== want.visible)
               report($sformatf("visible %b, expected %b", vis, want.visible));
            if (color !== want.color_index)
               report($sformatf("color_index %h, expected %h", color, want.color_index));
            if (pix !== want.pixel_value)
               report($sformatf("pixel_value %h, expected %h", pix, want.pixel_value));
         end
      endtask
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [1:0]                          req_command = '0;
   logic [7:0]                          req_write_data = '0;
   logic [7:0]                          req_screen_x = '0;
   logic [7:0]                          req_screen_y = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic                                rsp_visible;
   logic [15:0]                         rsp_color_index;
   logic [7:0]                          rsp_pixel_value;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [aipfb_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [aipfb_pkg::CSR_DAT_W-1:0]     csr_data = '0;

   plane_scoreboard sb;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;

   auto_increment_plane_framebuffer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_write_data(req_write_data),
      .req_screen_x(req_screen_x),
      .req_screen_y(req_screen_y),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_visible(rsp_visible),
      .rsp_color_index(rsp_color_index),
      .rsp_pixel_value(rsp_pixel_value),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // response side: check then pick the stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_pixel(rsp_visible, rsp_color_index, rsp_pixel_value);
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall) ||
          (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_csr(input logic [aipfb_pkg::CSR_IDX_W-1:0] idx,
                            input logic [aipfb_pkg::CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_config(input logic dir, input logic video, input logic [7:0] sx,
                               input logic [7:0] sy, input logic [7:0] pal);
      write_csr(aipfb_pkg::REG_DRAW_DIRECTION, {7'd0, dir});
      write_csr(aipfb_pkg::REG_VIDEO_ENABLE, {7'd0, video});
      write_csr(aipfb_pkg::REG_SCROLL_X, sx);
      write_csr(aipfb_pkg::REG_SCROLL_Y, sy);
      write_csr(aipfb_pkg::REG_PALETTE_BASE, pal);
   endtask

   task automatic send_request(input aipfb_pkg::cmd_type cmd, input logic [7:0] data,
                               input logic [7:0] sx, input logic [7:0] sy);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_write_data <= data;
      req_screen_x <= sx;
      req_screen_y <= sy;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(cmd, data, sx, sy);
   endtask

   // drop req_valid and wait for every outstanding response
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_request();
      int unsigned                  roll;
      aipfb_pkg::cmd_type           cmd;
      logic [7:0]                   data;
      logic [7:0]                   sx;
      logic [7:0]                   sy;
      logic [aipfb_pkg::ADDR_W-1:0] addr;
      roll = $urandom_range(99);
      data = 8'($urandom);
      sx = 8'($urandom);
      sy = 8'($urandom);
      if (roll < 35) begin
         cmd = aipfb_pkg::CMD_WRITE_PIXEL;
         if ($urandom_range(15) == 0) data = '0;
      end else if (roll < 42) begin
         cmd = aipfb_pkg::CMD_LOAD_COLUMN;
      end else if (roll < 49) begin
         cmd = aipfb_pkg::CMD_LOAD_ROW;
      end else begin
         cmd = aipfb_pkg::CMD_SCREEN_READ;
         // aim most reads at recently drawn cells through the scroll offsets
         if (sb.drawn.size() > 0 && $urandom_range(99) < 75) begin
            addr = sb.drawn[$urandom_range(sb.drawn.size() - 1)];
            sy = addr[15:8] - sb.regs.scroll_y;
            sx = addr[7:0] - sb.regs.scroll_x;
         end
      end
      send_request(cmd, data, sx, sy);
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // column drawing with wrap at the right edge, full palette bank
      write_config(1'b1, 1'b1, 8'd0, 8'd0, 8'hff);
      send_request(aipfb_pkg::CMD_LOAD_ROW, 8'd255, 8'd0, 8'd0);
      send_request(aipfb_pkg::CMD_LOAD_COLUMN, 8'd254, 8'd0, 8'd0);
      send_request(aipfb_pkg::CMD_WRITE_PIXEL, 8'hff, 8'd0, 8'd0);
      send_request(aipfb_pkg::CMD_WRITE_PIXEL, 8'h01, 8'd0, 8'd0);
      send_request(aipfb_pkg::CMD_WRITE_PIXEL, 8'h80, 8'd0, 8'd0);
      send_request(aipfb_pkg::CMD_WRITE_PIXEL, 8'h00, 8'd0, 8'd0);
      send_request(aipfb_pkg::CMD_SCREEN_READ, 8'd0, 8'd254, 8'd255);
      send_request(aipfb_pkg::CMD_SCREEN_READ, 8'd0, 8'd255, 8'd255);
      send_request(aipfb_pkg::CMD_SCREEN_READ, 8'd0, 8'd0, 8'd255);
      send_request(aipfb_pkg::CMD_SCREEN_READ, 8'd0, 8'd1, 8'd255);
      send_request(aipfb_pkg::CMD_SCREEN_READ, 8'd0, 8'd0, 8'd0);
      drain();

      // row drawing with wrap at the bottom, video off, maximum scroll
      write_config(1'b0, 1'b0, 8'd255, 8'd255, 8'd0);
      for (int i = aipfb_pkg::REG_PALETTE_BASE + 1; i < 2 ** aipfb_pkg::CSR_IDX_W; i++)
         write_csr(i[aipfb_pkg::CSR_IDX_W-1:0], 8'hff);
      send_request(aipfb_pkg::CMD_LOAD_ROW, 8'd255, 8'd0, 8'd0);
      send_request(aipfb_pkg::CMD_LOAD_COLUMN, 8'd0, 8'd0, 8'd0);
      send_request(aipfb_pkg::CMD_WRITE_PIXEL, 8'h55, 8'd0, 8'd0);
      send_request(aipfb_pkg::CMD_WRITE_PIXEL, 8'haa, 8'd0, 8'd0);
      send_request(aipfb_pkg::CMD_SCREEN_READ, 8'd0, 8'd1, 8'd0);
      send_request(aipfb_pkg::CMD_SCREEN_READ, 8'd0, 8'd1, 8'd1);
      send_request(aipfb_pkg::CMD_SCREEN_READ, 8'd0, 8'd0, 8'd0);
      send_request(aipfb_pkg::CMD_SCREEN_READ, 8'd0, 8'd255, 8'd255);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         int spare_idx;
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 82; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 82; end
            default: begin send_idle_pct = 21; stall_pct = 21; end
         endcase
         if (p == 0)
            write_config(1'b1, 1'b1, 8'd255, 8'd255, 8'd255);
         else if (p == 1)
            write_config(1'b0, 1'b1, 8'd0, 8'd0, 8'd0);
         else
            write_config(1'($urandom), $urandom_range(99) < 85, 8'($urandom),
                         8'($urandom), 8'($urandom));
         if (p % 3 == 2) begin
            spare_idx = $urandom_range(2 ** aipfb_pkg::CSR_IDX_W - 1,
                                       aipfb_pkg::REG_PALETTE_BASE + 1);
            write_csr(spare_idx[aipfb_pkg::CSR_IDX_W-1:0], 8'($urandom));
         end
         for (int n = 0; n < PHASE_REQUESTS; n++) random_request();
         drain();
      end

      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
